// ===== rtl/ftfd_pkg.sv =====
// Shared types and constants for the force/torque frame decoder.
// Holds frame header codes, status codes, the calibration tables and the MAC control struct.
`default_nettype none
package ftfd_pkg;

  localparam int MAXCH = 8;
  localparam int DIFF_W = 17;
  localparam int COEF_W = 32;
  localparam int PROD_W = DIFF_W + COEF_W;
  localparam int ACC_W = 56;
  localparam int FRAC_SHIFT = 14;
  localparam int RES_W = ACC_W - FRAC_SHIFT + 1;

  localparam logic [7:0] HDR_BYTE0 = 8'hAA;
  localparam logic [7:0] HDR_BYTE1 = 8'h55;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_CSUM = 2'd1;
  localparam logic [1:0] ST_HDR = 2'd2;

  // half an output LSB, preloaded into the accumulator
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(8192);

  localparam logic signed [DIFF_W-1:0] ZERO_CNT [MAXCH] = '{
    17'sd32715, 17'sd32693, 17'sd32689, 17'sd32681, 17'sd32703, 17'sd32735, 17'sd0, 17'sd0
  };

  localparam logic signed [COEF_W-1:0] COEF [MAXCH][MAXCH] = '{
    '{32'sd59467, -32'sd33073, 32'sd135051, 32'sd3992901,
      32'sd6634, 32'sd3826148, 32'sd0, 32'sd0},
    '{-32'sd44144, -32'sd4554660, 32'sd1206, 32'sd2294344,
      32'sd64676, -32'sd2248704, 32'sd0, 32'sd0},
    '{32'sd12076472, -32'sd31711, 32'sd12074717, -32'sd41928,
      32'sd12138727, 32'sd260963, 32'sd0, 32'sd0},
    '{32'sd1151, -32'sd2251, 32'sd63869, 32'sd629,
      -32'sd54537, -32'sd949, 32'sd0, 32'sd0},
    '{-32'sd70487, -32'sd687, 32'sd33246, -32'sd358,
      32'sd34055, -32'sd737, 32'sd0, 32'sd0},
    '{32'sd287, 32'sd27326, 32'sd835, 32'sd22632,
      32'sd125, -32'sd24827, 32'sd0, 32'sd0},
    '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
    '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0}
  };

  localparam logic signed [32:0] OFFSET_Q16 [MAXCH] = '{
    33'sd140784, 33'sd72961, 33'sd72889, 33'sd1710, 33'sd1442, 33'sd1363, 33'sd0, 33'sd0
  };

  typedef struct packed {
    logic mul_en;
    logic acc_en;
    logic acc_first;
  } mac_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/ftfd_mac.sv =====
// Shared multiply-accumulate unit: registered 17x32 product, then 56-bit accumulate.
// Depends on ftfd_pkg for widths, rounding preload and the control struct.
`default_nettype none
module ftfd_mac (
  input  wire logic                                clk,
  input  wire ftfd_pkg::mac_ctrl_t                 ctrl,
  input  wire logic signed [ftfd_pkg::DIFF_W-1:0]  diff,
  input  wire logic signed [ftfd_pkg::COEF_W-1:0]  coef,
  output logic signed [ftfd_pkg::ACC_W-1:0]        acc
);

  logic signed [ftfd_pkg::PROD_W-1:0] prod_r;
  logic signed [ftfd_pkg::ACC_W-1:0]  acc_r;
  logic signed [ftfd_pkg::ACC_W-1:0]  acc_base;

  assign acc_base = ctrl.acc_first ? ftfd_pkg::ROUND_HALF : acc_r;

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= diff * coef;
    end
    if (ctrl.acc_en) begin
      acc_r <= acc_base + ftfd_pkg::ACC_W'(prod_r);
    end
  end

  assign acc = acc_r;

endmodule
`default_nettype wire

// ===== rtl/force_torque_frame_decoder.sv =====
// Force/torque frame decoder: byte-wise frame parse, checksum, then 6x6 calibration.
// Bad frame: error word appears in the cycle after the checksum byte; a good frame runs
// S_MUL and S_ACC per channel, then S_OUT, for each axis on the single shared MAC.
// Throughput: one byte per cycle while parsing and no output word is pending; input stalls during the matrix pass.
// Reset (rst_n, synchronous): parser idle until a frame_start byte, no output pending.
// Depends on ftfd_pkg and ftfd_mac.
`default_nettype none
module force_torque_frame_decoder #(
  parameter int CHANNELS = 6
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_frame_start,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_axis,
  output logic signed [31:0] out_force_value,
  output logic [1:0]       out_status,
  output logic             out_last
);

  localparam int FRAME_LEN = 7 + 2 * CHANNELS;
  localparam int SUM_POS = 6 + 2 * CHANNELS;
  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNELS - 1);

  localparam logic [1:0] S_BYTES = 2'd0;
  localparam logic [1:0] S_MUL = 2'd1;
  localparam logic [1:0] S_ACC = 2'd2;
  localparam logic [1:0] S_OUT = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [4:0]       pos_r;
  logic [7:0]       csum_r;
  logic             hdr_good_r;
  logic [7:0]       hi_hold_r;
  logic [15:0]      count_r [CHANNELS];
  logic [IDX_W-1:0] i_r, i_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;

  logic             out_valid_r;
  logic [2:0]       out_axis_r;
  logic [31:0]      out_value_r;
  logic [1:0]       out_status_r;
  logic             out_last_r;

  logic             in_acc;
  logic [4:0]       cur_pos;
  logic [4:0]       off;
  logic [2:0]       wr_ch;
  logic             out_free;
  logic             out_load;

  ftfd_pkg::mac_ctrl_t mac_ctrl;
  logic signed [ftfd_pkg::DIFF_W-1:0] diff;
  logic signed [ftfd_pkg::COEF_W-1:0] coef;
  logic signed [ftfd_pkg::ACC_W-1:0]  acc;
  logic signed [ftfd_pkg::RES_W-1:0]  res;
  logic [31:0]                        sat_val;

  assign in_stall = (state_r != S_BYTES) || out_valid_r;
  assign in_acc = in_valid && !in_stall;
  assign cur_pos = in_frame_start ? 5'd0 : pos_r;
  assign off = cur_pos - 5'd6;
  assign wr_ch = off[3:1];
  assign out_free = !out_valid_r || !out_stall;

  // a word enters the output register: an error word at the checksum byte of a bad frame, or an axis word
  assign out_load = ((state_r == S_BYTES) && in_acc && (cur_pos == 5'(SUM_POS))
                     && (!hdr_good_r || (csum_r != in_data_byte)))
                  || ((state_r == S_OUT) && out_free);

  assign diff = ftfd_pkg::DIFF_W'({1'b0, count_r[k_r]}) - ftfd_pkg::ZERO_CNT[3'(k_r)];
  assign coef = ftfd_pkg::COEF[3'(i_r)][3'(k_r)];

  ftfd_mac u_mac (
    .clk  (clk),
    .ctrl (mac_ctrl),
    .diff (diff),
    .coef (coef),
    .acc  (acc)
  );

  // drop the 14 fraction bits, add the axis offset, clamp to 32 bits
  assign res = ftfd_pkg::RES_W'($signed(acc[ftfd_pkg::ACC_W-1:ftfd_pkg::FRAC_SHIFT]))
             + ftfd_pkg::RES_W'(ftfd_pkg::OFFSET_Q16[3'(i_r)]);

  always_comb begin
    if (res > ftfd_pkg::RES_W'(32'sh7FFFFFFF)) begin
      sat_val = 32'h7FFFFFFF;
    end else if (res < -ftfd_pkg::RES_W'(33'sh080000000)) begin
      sat_val = 32'h80000000;
    end else begin
      sat_val = res[31:0];
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    i_nxt = i_r;
    k_nxt = k_r;
    mac_ctrl = '0;
    unique case (state_r)
      S_BYTES: begin
        if (in_acc && (cur_pos == 5'(SUM_POS)) && hdr_good_r
            && (csum_r == in_data_byte)) begin
          state_nxt = S_MUL;
          i_nxt = '0;
          k_nxt = '0;
        end
      end
      S_MUL: begin
        mac_ctrl.mul_en = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        mac_ctrl.acc_en = 1'b1;
        mac_ctrl.acc_first = (k_r == '0);
        if (k_r == LAST_IDX) begin
          state_nxt = S_OUT;
        end else begin
          k_nxt = k_r + 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_OUT: begin
        if (out_free) begin
          k_nxt = '0;
          if (i_r == LAST_IDX) begin
            state_nxt = S_BYTES;
          end else begin
            i_nxt = i_r + 1'b1;
            state_nxt = S_MUL;
          end
        end
      end
      default: state_nxt = S_BYTES;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_BYTES;
      pos_r <= 5'(FRAME_LEN);
      csum_r <= '0;
      hdr_good_r <= 1'b0;
      hi_hold_r <= '0;
      i_r <= '0;
      k_r <= '0;
    end else begin
      state_r <= state_nxt;
      i_r <= i_nxt;
      k_r <= k_nxt;
      if (in_acc && (cur_pos < 5'(FRAME_LEN))) begin
        pos_r <= cur_pos + 5'd1;
        if (cur_pos == 5'd0) begin
          hdr_good_r <= (in_data_byte == ftfd_pkg::HDR_BYTE0);
          csum_r <= '0;
        end else if (cur_pos == 5'd1) begin
          hdr_good_r <= hdr_good_r && (in_data_byte == ftfd_pkg::HDR_BYTE1);
        end else if ((cur_pos >= 5'd6) && (cur_pos < 5'(SUM_POS))) begin
          csum_r <= csum_r + in_data_byte;
          if (!off[0]) begin
            hi_hold_r <= in_data_byte;
          end
        end
      end
    end
  end

  // count store: written on the low byte of each channel
  always_ff @(posedge clk) begin
    for (int j = 0; j < CHANNELS; j++) begin
      if (in_acc && (cur_pos >= 5'd6) && (cur_pos < 5'(SUM_POS)) && off[0]
          && (wr_ch == 3'(j))) begin
        count_r[j] <= {hi_hold_r, in_data_byte};
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_BYTES) begin
      if (in_acc && (cur_pos == 5'(SUM_POS))) begin
        out_axis_r <= 3'd0;
        out_value_r <= '0;
        out_last_r <= 1'b1;
        out_status_r <= hdr_good_r ? ftfd_pkg::ST_CSUM : ftfd_pkg::ST_HDR;
      end
    end else if ((state_r == S_OUT) && out_free) begin
      out_axis_r <= 3'(i_r);
      out_value_r <= sat_val;
      out_last_r <= (i_r == LAST_IDX);
      out_status_r <= ftfd_pkg::ST_OK;
    end
  end

  assign out_valid = out_valid_r;
  assign out_axis = out_axis_r;
  assign out_force_value = out_value_r;
  assign out_status = out_status_r;
  assign out_last = out_last_r;

endmodule
`default_nettype wire
